// ===== hdl/platform_motion_integrator_assert.svh =====
// Assertion macros used by the motion integrator RTL.
`ifndef PLATFORM_MOTION_INTEGRATOR_ASSERT_SVH
`define PLATFORM_MOTION_INTEGRATOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PMI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("motion integrator check failed");

// Check that cons holds in the cycle after ante.
`define PMI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("motion integrator check failed");

`endif

// ===== hdl/pmi_pkg.sv =====
// Shared types and constants of the motion integrator.
package pmi_pkg;

    localparam int WORD_W    = 32;
    localparam int SPEED_W   = 31;
    localparam int SIZE_W    = 12;
    localparam int ROUND_W   = 16;
    localparam int REG_IDX_W = 3;

    localparam logic signed [WORD_W-1:0]  WORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0]  WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [ROUND_W-1:0] ROUND_MAX = 16'sh7FFF;
    localparam logic signed [ROUND_W-1:0] ROUND_MIN = 16'sh8000;
    localparam logic [SPEED_W-1:0]        SPEED_MAX = 31'h7FFF_FFFF;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GRAVITY_X  = 3'd0,
        REG_GRAVITY_Y  = 3'd1,
        REG_FRICTION_X = 3'd2,
        REG_FRICTION_Y = 3'd3,
        REG_TERMINAL_X = 3'd4,
        REG_TERMINAL_Y = 3'd5,
        REG_WIDTH      = 3'd6,
        REG_HEIGHT     = 3'd7
    } reg_idx_t;

    // Contact controls for one axis.
    typedef struct packed {
        logic bleed;      // side along this axis touched: apply friction
        logic block_neg;  // side on the negative end touched
        logic block_pos;  // side on the positive end touched
    } axis_ctl_t;

    typedef struct packed {
        logic                     command;
        logic signed [WORD_W-1:0] load_pos_x;
        logic signed [WORD_W-1:0] load_pos_y;
        logic signed [WORD_W-1:0] load_vel_x;
        logic signed [WORD_W-1:0] load_vel_y;
        logic signed [WORD_W-1:0] accel_x;
        logic signed [WORD_W-1:0] accel_y;
        logic                     touch_top;
        logic                     touch_bottom;
        logic                     touch_left;
        logic                     touch_right;
    } item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  pos_x;
        logic signed [WORD_W-1:0]  pos_y;
        logic signed [WORD_W-1:0]  vel_x;
        logic signed [WORD_W-1:0]  vel_y;
        logic signed [ROUND_W-1:0] round_x;
        logic signed [ROUND_W-1:0] round_y;
        logic signed [WORD_W-1:0]  center_x;
        logic signed [WORD_W-1:0]  center_y;
        logic signed [ROUND_W-1:0] round_center_x;
        logic signed [ROUND_W-1:0] round_center_y;
    } result_t;

endpackage

// ===== hdl/pmi_item_if.sv =====
// Request channel carrying one step or load item.
interface pmi_item_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic signed [pmi_pkg::WORD_W-1:0] load_pos_x;
    logic signed [pmi_pkg::WORD_W-1:0] load_pos_y;
    logic signed [pmi_pkg::WORD_W-1:0] load_vel_x;
    logic signed [pmi_pkg::WORD_W-1:0] load_vel_y;
    logic signed [pmi_pkg::WORD_W-1:0] accel_x;
    logic signed [pmi_pkg::WORD_W-1:0] accel_y;
    logic                              touch_top;
    logic                              touch_bottom;
    logic                              touch_left;
    logic                              touch_right;

    modport source (
        output valid, command, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
               accel_x, accel_y, touch_top, touch_bottom, touch_left, touch_right,
        input  ready
    );
    modport sink (
        input  valid, command, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
               accel_x, accel_y, touch_top, touch_bottom, touch_left, touch_right,
        output ready
    );
endinterface

// ===== hdl/pmi_result_if.sv =====
// Result channel carrying the new motion state and derived positions.
interface pmi_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [pmi_pkg::WORD_W-1:0]  pos_x;
    logic signed [pmi_pkg::WORD_W-1:0]  pos_y;
    logic signed [pmi_pkg::WORD_W-1:0]  vel_x;
    logic signed [pmi_pkg::WORD_W-1:0]  vel_y;
    logic signed [pmi_pkg::ROUND_W-1:0] round_x;
    logic signed [pmi_pkg::ROUND_W-1:0] round_y;
    logic signed [pmi_pkg::WORD_W-1:0]  center_x;
    logic signed [pmi_pkg::WORD_W-1:0]  center_y;
    logic signed [pmi_pkg::ROUND_W-1:0] round_center_x;
    logic signed [pmi_pkg::ROUND_W-1:0] round_center_y;

    modport source (
        output valid, pos_x, pos_y, vel_x, vel_y, round_x, round_y,
               center_x, center_y, round_center_x, round_center_y,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, vel_x, vel_y, round_x, round_y,
               center_x, center_y, round_center_x, round_center_y,
        output ready
    );
endinterface

// ===== hdl/pmi_cfg_if.sv =====
// Register write channel.
interface pmi_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [pmi_pkg::REG_IDX_W-1:0]        index;
    logic [pmi_pkg::WORD_W-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/platform_motion_integrator.sv =====
// Platform motion integrator: fixed-point position/velocity update per request.
//
// Keeps position and velocity of one object in signed fixed point with FRAC_BITS
// fraction bits (Q16.16 by default). A load request sets position and velocity;
// a step request bleeds speed by friction along touched platforms, adds gravity
// and then acceleration (each clamped to the terminal speed, skipped when it
// would push into a touched side) and adds velocity to position with saturation.
// Every request returns exactly one result with the new state, the position
// rounded half away from zero, the center, and the rounded center.
// Rate: one request per cycle while the result side is ready. The three
// register stages (request capture, state update, result) each advance when
// the stage after them is free or emptying in the same cycle, so a stalled
// result backs the pipeline up one stage at a time and a bubble closes up
// behind it. The rate is set by the state update stage, where each request
// reads the position and velocity that the previous request wrote. Registers
// are written on the cfg channel, which is always ready; write them only while
// no request is in flight.
module platform_motion_integrator #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    pmi_cfg_if.sink         cfg,
    pmi_item_if.sink        item,
    pmi_result_if.source    result
);

    // Configuration registers.
    logic signed [pmi_pkg::WORD_W-1:0]  gravity_x_reg;
    logic signed [pmi_pkg::WORD_W-1:0]  gravity_y_reg;
    logic        [pmi_pkg::SPEED_W-1:0] friction_x_reg;
    logic        [pmi_pkg::SPEED_W-1:0] friction_y_reg;
    logic        [pmi_pkg::SPEED_W-1:0] terminal_x_reg;
    logic        [pmi_pkg::SPEED_W-1:0] terminal_y_reg;
    logic        [pmi_pkg::SIZE_W-1:0]  width_reg;
    logic        [pmi_pkg::SIZE_W-1:0]  height_reg;

    // Motion state.
    logic signed [pmi_pkg::WORD_W-1:0]  position_x_reg;
    logic signed [pmi_pkg::WORD_W-1:0]  position_y_reg;
    logic signed [pmi_pkg::WORD_W-1:0]  velocity_x_reg;
    logic signed [pmi_pkg::WORD_W-1:0]  velocity_y_reg;
    logic signed [pmi_pkg::WORD_W-1:0]  position_x_next;
    logic signed [pmi_pkg::WORD_W-1:0]  position_y_next;
    logic signed [pmi_pkg::WORD_W-1:0]  velocity_x_next;
    logic signed [pmi_pkg::WORD_W-1:0]  velocity_y_next;

    // Pipeline stages.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    pmi_pkg::item_t     s1_item_reg;
    pmi_pkg::item_t     s1_item_next;
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    pmi_pkg::result_t   out_data_reg;
    pmi_pkg::result_t   out_data_next;

    logic               item_acc;
    logic               out_free;
    logic               s2_adv;
    logic               s2_free;
    logic               s1_adv;

    pmi_pkg::axis_ctl_t ctl_x;
    pmi_pkg::axis_ctl_t ctl_y;
    logic signed [pmi_pkg::WORD_W-1:0]  step_pos_x;
    logic signed [pmi_pkg::WORD_W-1:0]  step_pos_y;
    logic signed [pmi_pkg::WORD_W-1:0]  step_vel_x;
    logic signed [pmi_pkg::WORD_W-1:0]  step_vel_y;

    logic signed [pmi_pkg::ROUND_W-1:0] view_round_x;
    logic signed [pmi_pkg::ROUND_W-1:0] view_round_y;
    logic signed [pmi_pkg::WORD_W-1:0]  view_center_x;
    logic signed [pmi_pkg::WORD_W-1:0]  view_center_y;
    logic signed [pmi_pkg::ROUND_W-1:0] view_rcenter_x;
    logic signed [pmi_pkg::ROUND_W-1:0] view_rcenter_y;

    //------------------------------------------------------------------
    // Configuration writes: always ready, decode the register index.
    //------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_x_reg  <= '0;
            gravity_y_reg  <= '0;
            friction_x_reg <= '0;
            friction_y_reg <= '0;
            terminal_x_reg <= pmi_pkg::SPEED_MAX;
            terminal_y_reg <= pmi_pkg::SPEED_MAX;
            width_reg      <= '0;
            height_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            case (pmi_pkg::reg_idx_t'(cfg.index))
                pmi_pkg::REG_GRAVITY_X:  gravity_x_reg  <= cfg.data;
                pmi_pkg::REG_GRAVITY_Y:  gravity_y_reg  <= cfg.data;
                pmi_pkg::REG_FRICTION_X: friction_x_reg <= cfg.data[pmi_pkg::SPEED_W-1:0];
                pmi_pkg::REG_FRICTION_Y: friction_y_reg <= cfg.data[pmi_pkg::SPEED_W-1:0];
                pmi_pkg::REG_TERMINAL_X: terminal_x_reg <= cfg.data[pmi_pkg::SPEED_W-1:0];
                pmi_pkg::REG_TERMINAL_Y: terminal_y_reg <= cfg.data[pmi_pkg::SPEED_W-1:0];
                pmi_pkg::REG_WIDTH:      width_reg      <= cfg.data[pmi_pkg::SIZE_W-1:0];
                pmi_pkg::REG_HEIGHT:     height_reg     <= cfg.data[pmi_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Flow control: each stage advances when the one after it is free or
    // emptying in the same cycle.
    //------------------------------------------------------------------
    assign out_free   = !out_valid_reg || result.ready;
    assign s2_adv     = s2_valid_reg && out_free;
    assign s2_free    = !s2_valid_reg || out_free;
    assign s1_adv     = s1_valid_reg && s2_free;
    assign item.ready = !s1_valid_reg || s2_free;
    assign item_acc   = item.valid && item.ready;

    always_comb
    begin
        s1_valid_next  = item_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        out_valid_next = s2_adv ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    //------------------------------------------------------------------
    // Stage 1: capture the request.
    //------------------------------------------------------------------
    always_comb
    begin
        s1_item_next.command      = item.command;
        s1_item_next.load_pos_x   = item.load_pos_x;
        s1_item_next.load_pos_y   = item.load_pos_y;
        s1_item_next.load_vel_x   = item.load_vel_x;
        s1_item_next.load_vel_y   = item.load_vel_y;
        s1_item_next.accel_x      = item.accel_x;
        s1_item_next.accel_y      = item.accel_y;
        s1_item_next.touch_top    = item.touch_top;
        s1_item_next.touch_bottom = item.touch_bottom;
        s1_item_next.touch_left   = item.touch_left;
        s1_item_next.touch_right  = item.touch_right;
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
            s1_item_reg <= s1_item_next;
    end

    //------------------------------------------------------------------
    // Stage 2: update the motion state. Top/bottom contact bleeds x speed
    // and blocks y pushes; left/right contact does the reverse.
    //------------------------------------------------------------------
    always_comb
    begin
        ctl_x.bleed     = s1_item_reg.touch_top || s1_item_reg.touch_bottom;
        ctl_x.block_neg = s1_item_reg.touch_left;
        ctl_x.block_pos = s1_item_reg.touch_right;
        ctl_y.bleed     = s1_item_reg.touch_left || s1_item_reg.touch_right;
        ctl_y.block_neg = s1_item_reg.touch_top;
        ctl_y.block_pos = s1_item_reg.touch_bottom;
    end

    pmi_axis_step u_step_x (
        .pos      (position_x_reg),
        .vel      (velocity_x_reg),
        .gravity  (gravity_x_reg),
        .accel    (s1_item_reg.accel_x),
        .friction (friction_x_reg),
        .terminal (terminal_x_reg),
        .ctl      (ctl_x),
        .pos_next (step_pos_x),
        .vel_next (step_vel_x)
    );

    pmi_axis_step u_step_y (
        .pos      (position_y_reg),
        .vel      (velocity_y_reg),
        .gravity  (gravity_y_reg),
        .accel    (s1_item_reg.accel_y),
        .friction (friction_y_reg),
        .terminal (terminal_y_reg),
        .ctl      (ctl_y),
        .pos_next (step_pos_y),
        .vel_next (step_vel_y)
    );

    always_comb
    begin
        if (s1_item_reg.command == pmi_pkg::CMD_LOAD)
        begin
            position_x_next = s1_item_reg.load_pos_x;
            position_y_next = s1_item_reg.load_pos_y;
            velocity_x_next = s1_item_reg.load_vel_x;
            velocity_y_next = s1_item_reg.load_vel_y;
        end
        else
        begin
            position_x_next = step_pos_x;
            position_y_next = step_pos_y;
            velocity_x_next = step_vel_x;
            velocity_y_next = step_vel_y;
        end
    end

    // The state registers double as the stage 2 payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_x_reg <= '0;
            position_y_reg <= '0;
            velocity_x_reg <= '0;
            velocity_y_reg <= '0;
        end
        else if (s1_adv)
        begin
            position_x_reg <= position_x_next;
            position_y_reg <= position_y_next;
            velocity_x_reg <= velocity_x_next;
            velocity_y_reg <= velocity_y_next;
        end
    end

    //------------------------------------------------------------------
    // Stage 3: derive rounded and center figures into the result register.
    //------------------------------------------------------------------
    pmi_axis_view #(.FRAC_BITS(FRAC_BITS)) u_view_x (
        .pos          (position_x_reg),
        .size         (width_reg),
        .rounded      (view_round_x),
        .center       (view_center_x),
        .round_center (view_rcenter_x)
    );

    pmi_axis_view #(.FRAC_BITS(FRAC_BITS)) u_view_y (
        .pos          (position_y_reg),
        .size         (height_reg),
        .rounded      (view_round_y),
        .center       (view_center_y),
        .round_center (view_rcenter_y)
    );

    always_comb
    begin
        out_data_next.pos_x          = position_x_reg;
        out_data_next.pos_y          = position_y_reg;
        out_data_next.vel_x          = velocity_x_reg;
        out_data_next.vel_y          = velocity_y_reg;
        out_data_next.round_x        = view_round_x;
        out_data_next.round_y        = view_round_y;
        out_data_next.center_x       = view_center_x;
        out_data_next.center_y       = view_center_y;
        out_data_next.round_center_x = view_rcenter_x;
        out_data_next.round_center_y = view_rcenter_y;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.pos_x          = out_data_reg.pos_x;
    assign result.pos_y          = out_data_reg.pos_y;
    assign result.vel_x          = out_data_reg.vel_x;
    assign result.vel_y          = out_data_reg.vel_y;
    assign result.round_x        = out_data_reg.round_x;
    assign result.round_y        = out_data_reg.round_y;
    assign result.center_x       = out_data_reg.center_x;
    assign result.center_y       = out_data_reg.center_y;
    assign result.round_center_x = out_data_reg.round_center_x;
    assign result.round_center_y = out_data_reg.round_center_y;

    //------------------------------------------------------------------
    // Checks.
    //------------------------------------------------------------------
`include "platform_motion_integrator_assert.svh"

    // A request leaving stage 1 always lands in stage 2.
    `PMI_ASSERT_NEXT(a_s1_to_s2, s1_adv, s2_valid_reg)

    // A load request writes its position verbatim into the state.
    `PMI_ASSERT_NEXT(a_load_pos,
        s1_adv && (s1_item_reg.command == pmi_pkg::CMD_LOAD),
        position_x_reg == $past(s1_item_reg.load_pos_x))

    // Freeze the state while the pipeline is fully backed up.
    `PMI_ASSERT_NEXT(a_state_hold,
        s2_valid_reg && out_valid_reg && !result.ready,
        $stable(position_x_reg) && $stable(velocity_x_reg))

    // Stage 2 can only empty into a free result register.
    `PMI_ASSERT_SAME(a_s2_drain, s2_adv, out_free)

endmodule

// ===== hdl/pmi_axis_step.sv =====
// One axis of the motion update: friction, gravity, acceleration, position.
module pmi_axis_step (
    input  logic signed [pmi_pkg::WORD_W-1:0]  pos,
    input  logic signed [pmi_pkg::WORD_W-1:0]  vel,
    input  logic signed [pmi_pkg::WORD_W-1:0]  gravity,
    input  logic signed [pmi_pkg::WORD_W-1:0]  accel,
    input  logic        [pmi_pkg::SPEED_W-1:0] friction,
    input  logic        [pmi_pkg::SPEED_W-1:0] terminal,
    input  pmi_pkg::axis_ctl_t                 ctl,
    output logic signed [pmi_pkg::WORD_W-1:0]  pos_next,
    output logic signed [pmi_pkg::WORD_W-1:0]  vel_next
);

    localparam int W  = pmi_pkg::WORD_W;
    localparam int WW = pmi_pkg::WORD_W + 1;

    // Add a push unless it drives into a touched side; clamp to +/- terminal.
    function automatic logic signed [W-1:0] push_clamp(
        input logic signed [W-1:0]            v,
        input logic signed [W-1:0]            a,
        input logic                           bn,
        input logic                           bp,
        input logic [pmi_pkg::SPEED_W-1:0]    t
    );
        logic signed [WW-1:0] sum;
        logic signed [WW-1:0] lim;
        logic signed [WW-1:0] neg_lim;
        logic                 apply;
        apply   = (!bn && (a < 0)) || (!bp && (a > 0));
        sum     = WW'(v) + WW'(a);
        lim     = {2'b00, t};
        neg_lim = -lim;
        if (!apply)
            push_clamp = v;
        else if (sum > lim)
            push_clamp = lim[W-1:0];
        else if (sum < neg_lim)
            push_clamp = neg_lim[W-1:0];
        else
            push_clamp = sum[W-1:0];
    endfunction

    logic signed [WW-1:0] vel_ext;
    logic signed [WW-1:0] fric_ext;
    logic signed [WW-1:0] vel_dec;
    logic signed [WW-1:0] vel_inc;
    logic signed [W-1:0]  vel_bled;
    logic signed [W-1:0]  vel_grav;
    logic signed [WW-1:0] pos_sum;

    always_comb
    begin
        vel_ext  = WW'(vel);
        fric_ext = {2'b00, friction};
        vel_dec  = vel_ext - fric_ext;
        vel_inc  = vel_ext + fric_ext;

        // Bleed speed toward zero without crossing it.
        if (!ctl.bleed)
            vel_bled = vel;
        else if (vel > 0)
            vel_bled = (vel_dec > 0) ? vel_dec[W-1:0] : '0;
        else
            vel_bled = (vel_inc < 0) ? vel_inc[W-1:0] : '0;

        vel_grav = push_clamp(vel_bled, gravity, ctl.block_neg, ctl.block_pos, terminal);
        vel_next = push_clamp(vel_grav, accel, ctl.block_neg, ctl.block_pos, terminal);

        pos_sum = WW'(pos) + WW'(vel_next);
        if (pos_sum[W] != pos_sum[W-1])
            pos_next = pos_sum[W] ? pmi_pkg::WORD_MIN : pmi_pkg::WORD_MAX;
        else
            pos_next = pos_sum[W-1:0];
    end

endmodule

// ===== hdl/pmi_axis_view.sv =====
// Derived position figures of one axis: rounded position and centers.
module pmi_axis_view #(
    parameter int FRAC_BITS = 16
) (
    input  logic signed [pmi_pkg::WORD_W-1:0]  pos,
    input  logic        [pmi_pkg::SIZE_W-1:0]  size,
    output logic signed [pmi_pkg::ROUND_W-1:0] rounded,
    output logic signed [pmi_pkg::WORD_W-1:0]  center,
    output logic signed [pmi_pkg::ROUND_W-1:0] round_center
);

    localparam int MAG_W = pmi_pkg::WORD_W + 1;
    localparam int QW    = MAG_W - FRAC_BITS;
    localparam int RW    = QW + 1;
    localparam int RCW   = ((RW > pmi_pkg::SIZE_W) ? RW : pmi_pkg::SIZE_W) + 1;
    localparam int XW    = (RCW > pmi_pkg::ROUND_W + 1) ? RCW : pmi_pkg::ROUND_W + 1;
    localparam int SHW   = pmi_pkg::SIZE_W + FRAC_BITS - 1;
    localparam int CW    = ((SHW + 1 > pmi_pkg::WORD_W) ? SHW + 1 : pmi_pkg::WORD_W) + 1;

    function automatic logic signed [pmi_pkg::ROUND_W-1:0] sat_round(
        input logic signed [XW-1:0] x
    );
        if (x > XW'(pmi_pkg::ROUND_MAX))
            sat_round = pmi_pkg::ROUND_MAX;
        else if (x < XW'(pmi_pkg::ROUND_MIN))
            sat_round = pmi_pkg::ROUND_MIN;
        else
            sat_round = x[pmi_pkg::ROUND_W-1:0];
    endfunction

    logic signed [MAG_W-1:0]          pos_ext;
    logic        [MAG_W-1:0]          mag;
    logic        [MAG_W-1:0]          biased;
    logic signed [RW-1:0]             q_ext;
    logic signed [RW-1:0]             r;
    logic signed [RCW-1:0]            half_size;
    logic signed [RCW-1:0]            rc;
    logic        [SHW-1:0]            shifted;
    logic signed [CW-1:0]             c;

    always_comb
    begin
        // Round half away from zero on the magnitude, then restore the sign.
        pos_ext = MAG_W'(pos);
        mag     = pos[pmi_pkg::WORD_W-1] ? -pos_ext : pos_ext;
        biased  = mag + (MAG_W'(1) << (FRAC_BITS - 1));
        q_ext   = {1'b0, biased[MAG_W-1:FRAC_BITS]};
        r       = pos[pmi_pkg::WORD_W-1] ? -q_ext : q_ext;
        rounded = sat_round(XW'(r));

        // Rounded center uses the unsaturated rounded position.
        half_size    = RCW'(size[pmi_pkg::SIZE_W-1:1]);
        rc           = RCW'(r) + half_size;
        round_center = sat_round(XW'(rc));

        shifted = SHW'(size) << (FRAC_BITS - 1);
        c       = CW'(pos) + CW'(shifted);
        if (c > CW'(pmi_pkg::WORD_MAX))
            center = pmi_pkg::WORD_MAX;
        else if (c < CW'(pmi_pkg::WORD_MIN))
            center = pmi_pkg::WORD_MIN;
        else
            center = c[pmi_pkg::WORD_W-1:0];
    end

endmodule

// ===== bench/pmi_motion_checker.sv =====
// Watches the motion integrator channels, predicts every result and compares it.
`timescale 1ns / 1ps

module pmi_motion_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    pmi_cfg_if    cfg,
    pmi_item_if   item,
    pmi_result_if result,
    output int    fails,
    output int    pending
);
    import pmi_pkg::*;

    localparam longint W_LO = longint'(WORD_MIN);
    localparam longint W_HI = longint'(WORD_MAX);
    localparam longint R_LO = longint'(ROUND_MIN);
    localparam longint R_HI = longint'(ROUND_MAX);

    // register copy
    logic signed [WORD_W-1:0] grav_x, grav_y;
    logic [SPEED_W-1:0]       fric_x, fric_y, term_x, term_y;
    logic [SIZE_W-1:0]        size_x, size_y;

    // motion state copy
    logic signed [WORD_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;

    result_t expected_motion[$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Lose speed toward zero without crossing it.
    function automatic longint bleed_speed(longint v, longint f);
        if (v > 0)
            return (v - f > 0) ? v - f : 0;
        return (v + f < 0) ? v + f : 0;
    endfunction

    // Add a push unless it points into a touched side; zero push never clamps.
    function automatic longint apply_push(longint v, longint a, logic block_neg,
                                          logic block_pos, longint limit);
        if ((!block_neg && a < 0) || (!block_pos && a > 0))
            return clamp(v + a, -limit, limit);
        return v;
    endfunction

    function automatic longint round_half_away(longint p);
        longint half;
        half = longint'(1) << (FRAC_BITS - 1);
        if (p >= 0)
            return (p + half) >>> FRAC_BITS;
        return -((-p + half) >>> FRAC_BITS);
    endfunction

    function automatic void derive_axis(input longint p, input longint span,
                                        output logic signed [ROUND_W-1:0] rnd,
                                        output logic signed [WORD_W-1:0] ctr,
                                        output logic signed [ROUND_W-1:0] rnd_ctr);
        longint r;
        r       = round_half_away(p);
        rnd     = ROUND_W'(clamp(r, R_LO, R_HI));
        ctr     = WORD_W'(clamp(p + (span << (FRAC_BITS - 1)), W_LO, W_HI));
        rnd_ctr = ROUND_W'(clamp(r + (span >> 1), R_LO, R_HI));
    endfunction

    function automatic result_t advance_motion(item_t req);
        longint  px, py, vx, vy;
        result_t r;
        if (req.command == CMD_LOAD)
        begin
            px = $signed(req.load_pos_x);
            py = $signed(req.load_pos_y);
            vx = $signed(req.load_vel_x);
            vy = $signed(req.load_vel_y);
        end
        else
        begin
            px = pos_x_q;
            py = pos_y_q;
            vx = vel_x_q;
            vy = vel_y_q;
            if (req.touch_top || req.touch_bottom)
                vx = bleed_speed(vx, fric_x);
            if (req.touch_left || req.touch_right)
                vy = bleed_speed(vy, fric_y);
            vx = apply_push(vx, grav_x, req.touch_left, req.touch_right, term_x);
            vy = apply_push(vy, grav_y, req.touch_top, req.touch_bottom, term_y);
            vx = apply_push(vx, $signed(req.accel_x), req.touch_left, req.touch_right,
                            term_x);
            vy = apply_push(vy, $signed(req.accel_y), req.touch_top, req.touch_bottom,
                            term_y);
            px = clamp(px + vx, W_LO, W_HI);
            py = clamp(py + vy, W_LO, W_HI);
        end
        pos_x_q = WORD_W'(px);
        pos_y_q = WORD_W'(py);
        vel_x_q = WORD_W'(vx);
        vel_y_q = WORD_W'(vy);
        r.pos_x = pos_x_q;
        r.pos_y = pos_y_q;
        r.vel_x = vel_x_q;
        r.vel_y = vel_y_q;
        derive_axis(px, size_x, r.round_x, r.center_x, r.round_center_x);
        derive_axis(py, size_y, r.round_y, r.center_y, r.round_center_y);
        return r;
    endfunction

    task automatic compare_field(string field, logic signed [WORD_W-1:0] want,
                                 logic signed [WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   req;
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            grav_x  = '0;
            grav_y  = '0;
            fric_x  = '0;
            fric_y  = '0;
            term_x  = SPEED_MAX;
            term_y  = SPEED_MAX;
            size_x  = '0;
            size_y  = '0;
            pos_x_q = '0;
            pos_y_q = '0;
            vel_x_q = '0;
            vel_y_q = '0;
            expected_motion.delete();
            fails   = 0;
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (reg_idx_t'(cfg.index))
                    REG_GRAVITY_X:  grav_x = cfg.data;
                    REG_GRAVITY_Y:  grav_y = cfg.data;
                    REG_FRICTION_X: fric_x = cfg.data[SPEED_W-1:0];
                    REG_FRICTION_Y: fric_y = cfg.data[SPEED_W-1:0];
                    REG_TERMINAL_X: term_x = cfg.data[SPEED_W-1:0];
                    REG_TERMINAL_Y: term_y = cfg.data[SPEED_W-1:0];
                    REG_WIDTH:      size_x = cfg.data[SIZE_W-1:0];
                    REG_HEIGHT:     size_y = cfg.data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                req = '{command: item.command,
                        load_pos_x: item.load_pos_x, load_pos_y: item.load_pos_y,
                        load_vel_x: item.load_vel_x, load_vel_y: item.load_vel_y,
                        accel_x: item.accel_x, accel_y: item.accel_y,
                        touch_top: item.touch_top, touch_bottom: item.touch_bottom,
                        touch_left: item.touch_left, touch_right: item.touch_right};
                expected_motion.push_back(advance_motion(req));
            end
            if (result.valid && result.ready)
            begin
                seen = '{pos_x: result.pos_x, pos_y: result.pos_y,
                         vel_x: result.vel_x, vel_y: result.vel_y,
                         round_x: result.round_x, round_y: result.round_y,
                         center_x: result.center_x, center_y: result.center_y,
                         round_center_x: result.round_center_x,
                         round_center_y: result.round_center_y};
                if (expected_motion.size() == 0)
                begin
                    $error("result with no request waiting");
                    fails++;
                end
                else
                begin
                    want = expected_motion.pop_front();
                    compare_field("pos_x", want.pos_x, seen.pos_x);
                    compare_field("pos_y", want.pos_y, seen.pos_y);
                    compare_field("vel_x", want.vel_x, seen.vel_x);
                    compare_field("vel_y", want.vel_y, seen.vel_y);
                    compare_field("round_x", want.round_x, seen.round_x);
                    compare_field("round_y", want.round_y, seen.round_y);
                    compare_field("center_x", want.center_x, seen.center_x);
                    compare_field("center_y", want.center_y, seen.center_y);
                    compare_field("round_center_x", want.round_center_x,
                                  seen.round_center_x);
                    compare_field("round_center_y", want.round_center_y,
                                  seen.round_center_y);
                end
            end
            pending = expected_motion.size();
        end
    end

endmodule

// ===== bench/platform_motion_integrator_tb.sv =====
// Stimulus and verdict for the motion integrator, checked by pmi_motion_checker.
`timescale 1ns / 1ps

module platform_motion_integrator_tb;
    import pmi_pkg::*;

    localparam int FRAC              = 16;
    localparam int ITEMS_PER_SETTING = 180;
    localparam int RANDOM_SETTINGS   = 6;

    // contact side flags, ordered {top, bottom, left, right}
    localparam logic [3:0] TOUCH_NONE   = 4'b0000;
    localparam logic [3:0] TOUCH_TOP    = 4'b1000;
    localparam logic [3:0] TOUCH_BOTTOM = 4'b0100;
    localparam logic [3:0] TOUCH_LEFT   = 4'b0010;
    localparam logic [3:0] TOUCH_RIGHT  = 4'b0001;
    localparam logic [3:0] TOUCH_ALL    = 4'b1111;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   send_idle_pct;
    int   ready_idle_pct;

    pmi_cfg_if    cfg_ch();
    pmi_item_if   item_ch();
    pmi_result_if result_ch();

    platform_motion_integrator #(
        .FRAC_BITS (FRAC)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    pmi_motion_checker #(
        .FRAC_BITS (FRAC)
    ) motion_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .item    (item_ch),
        .result  (result_ch),
        .fails   (fails),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hard stop: far beyond the slowest legal run (about 1100 requests, each
    // waiting out a heavily stalled receiver).
    initial
    begin
        #5_000_000;
        $display("FAIL platform_motion_integrator");
        $finish;
    end

    // Result side: drop ready at random, one decision per falling edge.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= ready_idle_pct);
        end
    end

    // Write one register; enter and leave just after a falling edge.
    task automatic write_reg(reg_idx_t idx, logic [WORD_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
    endtask

    // Offer one request, idling first at the sender's rate. Valid stays high
    // into the next call so back-to-back requests need no extra assignment.
    task automatic send_item(item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.command      <= req.command;
        item_ch.load_pos_x   <= req.load_pos_x;
        item_ch.load_pos_y   <= req.load_pos_y;
        item_ch.load_vel_x   <= req.load_vel_x;
        item_ch.load_vel_y   <= req.load_vel_y;
        item_ch.accel_x      <= req.accel_x;
        item_ch.accel_y      <= req.accel_y;
        item_ch.touch_top    <= req.touch_top;
        item_ch.touch_bottom <= req.touch_bottom;
        item_ch.touch_left   <= req.touch_left;
        item_ch.touch_right  <= req.touch_right;
        item_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (!(item_ch.valid && item_ch.ready));
        @(negedge clk);
    endtask

    // Hold the request side quiet until every result is back, then let the
    // pipeline drain.
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all eight registers with one of the prepared settings.
    task automatic apply_setting(int n);
        logic [WORD_W-1:0] gx, gy, fx, fy, tx, ty, wd, ht;
        case (n)
            0:
            begin
                // mild physics, largest object
                gx = -32'sh0000_2000;
                gy = 32'sh0000_4000;
                fx = 32'h0000_8000;
                fy = 32'h0000_8000;
                tx = 32'h0004_0000;
                ty = 32'h0004_0000;
                wd = 32'd4095;
                ht = 32'd4095;
            end
            1, 6:
            begin
                // game-like values
                gx = 0;
                gy = $urandom_range(32'h0000_8000);
                fx = $urandom_range(32'h0001_0000);
                fy = $urandom_range(32'h0001_0000);
                tx = $urandom_range(32'h0008_0000, 32'h0001_0000);
                ty = $urandom_range(32'h0008_0000, 32'h0001_0000);
                wd = $urandom_range(64, 8);
                ht = $urandom_range(64, 8);
            end
            2:
            begin
                // gravity at both extremes, everything else at its top end
                gx = WORD_MAX;
                gy = WORD_MIN;
                fx = SPEED_MAX;
                fy = SPEED_MAX;
                tx = SPEED_MAX;
                ty = SPEED_MAX;
                wd = 32'd4095;
                ht = 32'd4095;
            end
            3:
            begin
                // zero terminal speed pins every pushed velocity to zero
                gx = $urandom_range(32'h0001_0000);
                gy = -32'sh0000_4000;
                fx = 0;
                fy = 0;
                tx = 0;
                ty = 0;
                wd = 0;
                ht = 0;
            end
            4:
            begin
                // raw words, upper bits included to exercise field masking
                gx = $urandom;
                gy = $urandom;
                fx = $urandom;
                fy = $urandom;
                tx = $urandom;
                ty = $urandom;
                wd = $urandom;
                ht = $urandom;
            end
            default:
            begin
                gx = WORD_MIN;
                gy = WORD_MAX;
                fx = 0;
                fy = 0;
                tx = $urandom_range(32'h0100_0000);
                ty = $urandom_range(32'h0100_0000);
                wd = 1;
                ht = 32'd4095;
            end
        endcase
        write_reg(REG_GRAVITY_X, gx);
        write_reg(REG_GRAVITY_Y, gy);
        write_reg(REG_FRICTION_X, fx);
        write_reg(REG_FRICTION_Y, fy);
        write_reg(REG_TERMINAL_X, tx);
        write_reg(REG_TERMINAL_Y, ty);
        write_reg(REG_WIDTH, wd);
        write_reg(REG_HEIGHT, ht);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic item_t step_req(logic signed [WORD_W-1:0] ax,
                                       logic signed [WORD_W-1:0] ay, logic [3:0] sides);
        item_t req;
        req         = '0;
        req.command = CMD_STEP;
        req.accel_x = ax;
        req.accel_y = ay;
        {req.touch_top, req.touch_bottom, req.touch_left, req.touch_right} = sides;
        return req;
    endfunction

    function automatic item_t load_req(logic signed [WORD_W-1:0] px,
                                       logic signed [WORD_W-1:0] py,
                                       logic signed [WORD_W-1:0] vx,
                                       logic signed [WORD_W-1:0] vy);
        item_t req;
        req            = '0;
        req.command    = CMD_LOAD;
        req.load_pos_x = px;
        req.load_pos_y = py;
        req.load_vel_x = vx;
        req.load_vel_y = vy;
        return req;
    endfunction

    // Mostly zero or small values, with raw words and near-limit values mixed in.
    function automatic logic signed [WORD_W-1:0] random_word();
        logic signed [WORD_W-1:0] w;
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
            w = '0;
        else if (pick < 70)
        begin
            w = $urandom_range(32'h0002_0000);
            if ($urandom_range(1))
                w = -w;
        end
        else if (pick < 85)
            w = $urandom;
        else if (pick < 92)
            w = WORD_MAX - $urandom_range(32'h0004_0000);
        else
            w = WORD_MIN + $urandom_range(32'h0004_0000);
        return w;
    endfunction

    // Mostly steps; ignored fields still carry random data.
    function automatic item_t random_request();
        item_t req;
        req.command      = ($urandom_range(99) < 12) ? CMD_LOAD : CMD_STEP;
        req.load_pos_x   = random_word();
        req.load_pos_y   = random_word();
        req.load_vel_x   = random_word();
        req.load_vel_y   = random_word();
        req.accel_x      = random_word();
        req.accel_y      = random_word();
        req.touch_top    = ($urandom_range(99) < 30);
        req.touch_bottom = ($urandom_range(99) < 30);
        req.touch_left   = ($urandom_range(99) < 30);
        req.touch_right  = ($urandom_range(99) < 30);
        return req;
    endfunction

    initial
    begin
        // Drive every input to a known value before reset.
        rst_n                = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_GRAVITY_X;
        cfg_ch.data          = '0;
        item_ch.valid        = 1'b0;
        item_ch.command      = CMD_STEP;
        item_ch.load_pos_x   = '0;
        item_ch.load_pos_y   = '0;
        item_ch.load_vel_x   = '0;
        item_ch.load_vel_y   = '0;
        item_ch.accel_x      = '0;
        item_ch.accel_y      = '0;
        item_ch.touch_top    = 1'b0;
        item_ch.touch_bottom = 1'b0;
        item_ch.touch_left   = 1'b0;
        item_ch.touch_right  = 1'b0;
        send_idle_pct        = 0;
        ready_idle_pct       = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests on the reset settings (no gravity, no friction,
        // full terminal speed, zero-size object).
        send_item(step_req(0, 0, TOUCH_NONE));                 // zero push leaves speed
        send_item(step_req(WORD_MAX, WORD_MIN, TOUCH_NONE));   // push clamps at terminal
        send_item(step_req(WORD_MAX, WORD_MIN, TOUCH_NONE));   // position saturates
        send_item(step_req(WORD_MIN, WORD_MAX, TOUCH_ALL));    // every push blocked
        send_item(load_req(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
        send_item(step_req(0, 0, TOUCH_NONE));                 // position overflow
        send_item(load_req(32'sh0000_8000, -32'sh0000_8000, 0, 0));  // exact halves
        send_item(load_req(32'sh0000_7FFF, -32'sh0000_7FFF, 0, 0));  // just under half
        send_item(load_req(32'sh7FFF_8000, WORD_MIN, 0, 0));         // rounding overflow
        settle();

        // Directed requests with friction, gravity, small terminal and the
        // largest object size.
        apply_setting(0);
        send_item(load_req(WORD_MAX, WORD_MIN, 32'sh0003_0000, -32'sh0003_0000));
        send_item(step_req(0, 0, TOUCH_TOP));                  // bleed x, gravity y allowed
        send_item(step_req(0, 32'sh0001_0000, TOUCH_BOTTOM));  // downward push blocked
        send_item(step_req(32'sh0001_0000, 0, TOUCH_LEFT | TOUCH_RIGHT));  // both walls
        send_item(load_req(0, 0, 32'sh0000_4000, -32'sh0000_4000));
        send_item(step_req(0, 0, TOUCH_TOP | TOUCH_BOTTOM | TOUCH_LEFT));  // stop at zero
        send_item(step_req(32'sh0010_0000, -32'sh0010_0000, TOUCH_NONE)); // clamp
        send_item(step_req(-32'sh0010_0000, 32'sh0010_0000, TOUCH_LEFT | TOUCH_TOP));
        send_item(load_req(32'sh7FFF_0000, -32'sh7FFF_0000, 0, 0));  // rounded center limit
        send_item(load_req(-32'sh0000_8000, 32'sh0000_8000, 32'sh0000_1000, 0));
        settle();

        // Random requests under each setting. Idle the sender lightly and the
        // receiver heavily first, then swap, then run both flat out.
        for (int s = 1; s <= RANDOM_SETTINGS; s++)
        begin
            if (s <= 2)
            begin
                send_idle_pct  = 28;
                ready_idle_pct = 80;
            end
            else if (s <= 4)
            begin
                send_idle_pct  = 80;
                ready_idle_pct = 28;
            end
            else
            begin
                send_idle_pct  = 0;
                ready_idle_pct = 0;
            end
            apply_setting(s);
            repeat (ITEMS_PER_SETTING) send_item(random_request());
            settle();
        end

        if (fails == 0)
            $display("PASS platform_motion_integrator");
        else
            $display("FAIL platform_motion_integrator");
        $finish;
    end

endmodule

// ===== platform_motion_integrator.f =====
+incdir+hdl
hdl/pmi_pkg.sv
hdl/pmi_item_if.sv
hdl/pmi_result_if.sv
hdl/pmi_cfg_if.sv
hdl/pmi_axis_step.sv
hdl/pmi_axis_view.sv
hdl/platform_motion_integrator.sv
bench/pmi_motion_checker.sv
bench/platform_motion_integrator_tb.sv
